@@ hw/rtl/e2q_pkg.sv @@
// Package for the Euler-to-quaternion pipeline: fixed-point constants,
// CORDIC arctangent table and shared widths. No dependencies.
`timescale 1ns / 1ps
package e2q_pkg;

  localparam int AngW    = 15;
  localparam int QW      = 16;
  localparam int Frac    = 28;
  localparam int Iters   = 16;
  localparam int VW      = 34;   // Q.28 signed values with headroom
  localparam int SqW     = 60;   // radicand width for the square root
  localparam int RootW   = 30;
  localparam int NumW    = 36;   // off-diagonal numerator
  localparam int DivNW   = NumW + 14;
  localparam int DivDW   = RootW + 2;

  localparam logic signed [VW-1:0] PiQ     = 34'sd843314857;
  localparam logic signed [VW-1:0] HalfPiQ = 34'sd421657428;
  localparam logic signed [VW-1:0] GainQ   = 34'sd163008218;
  localparam logic signed [VW-1:0] OneQ    = 34'sd268435456;
  localparam logic signed [QW-1:0] Q14Max  = 16'sd16384;

  typedef enum logic [1:0] {SEL_S, SEL_X, SEL_Y, SEL_Z} sel_t;

  function automatic logic signed [VW-1:0] atan_q(input int i);
    logic signed [VW-1:0] r;
    case (i)
      0:  r = 34'sd210828714;
      1:  r = 34'sd124459457;
      2:  r = 34'sd65760959;
      3:  r = 34'sd33381290;
      4:  r = 34'sd16755422;
      5:  r = 34'sd8385879;
      6:  r = 34'sd4193963;
      7:  r = 34'sd2097109;
      8:  r = 34'sd1048571;
      9:  r = 34'sd524287;
      10: r = 34'sd262144;
      11: r = 34'sd131072;
      12: r = 34'sd65536;
      13: r = 34'sd32768;
      14: r = 34'sd16384;
      default: r = 34'sd8192;
    endcase
    return r;
  endfunction

  // product of two Q.28 values, floor shift
  function automatic logic signed [VW-1:0] qmul(input logic signed [VW-1:0] a,
                                               input logic signed [VW-1:0] b);
    logic signed [2*VW-1:0] p;
    p = a * b;
    return p[Frac +: VW];
  endfunction

  function automatic logic signed [QW-1:0] sat14(input logic signed [DivNW-1:0] v);
    logic signed [QW-1:0] r;
    if (v > DivNW'(Q14Max)) r = Q14Max;
    else if (v < -DivNW'(Q14Max)) r = -Q14Max;
    else r = v[QW-1:0];
    return r;
  endfunction

endpackage

@@ hw/rtl/euler_to_quaternion_top.sv @@
// Euler 3-2-1 angles to unit quaternion pipeline (CORDIC, DCM, Shepperd).
// Depends on e2q_pkg.
`timescale 1ns / 1ps
// Takes one angle triple per cycle while s_tready is high and returns one quaternion per triple.
// The pipeline is fully registered: an angle-reduction stage, 16 CORDIC stages,
// 3 matrix stages, 2 candidate stages, a 30-stage bit-per-cycle square root,
// a select stage, a 50-stage restoring divider and an output stage, 104 register
// stages in all. Whole-pipeline stall on s_tready low; a one-entry skid holds the
// older result so the input stays open while a single result waits.
module euler_to_quaternion_top
  import e2q_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // roll_angle[14:0], pitch_angle[29:15], yaw_angle[44:30]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata   // quat_scalar, quat_x, quat_y, quat_z (16 bits each)
);

  localparam int CS = Iters;          // CORDIC stages
  localparam int SQ = RootW;          // sqrt stages
  localparam int DV = DivNW;          // divider stages
  localparam int LAT = CS + 3 + 2 + SQ + 1 + DV + 1;

  // pipeline advance: move when the output side can take one more
  logic adv;
  logic [LAT-1:0] vld;
  logic out_full;
  logic [63:0] out_data;
  logic skid_full;
  logic [63:0] skid_data;

  assign adv = !skid_full;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[LAT-2:0], s_tvalid};
  end

  // ---------------- CORDIC: three lanes ----------------
  logic signed [VW-1:0] cx [3][CS+1];
  logic signed [VW-1:0] cy [3][CS+1];
  logic signed [VW-1:0] cz [3][CS+1];
  logic                 cn [3][CS+1];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic signed [AngW-1:0] a;
    logic signed [VW-1:0] z0;
    assign a  = s_tdata[l*AngW +: AngW];
    assign z0 = VW'(a) <<< 16;
    always_ff @(posedge clk) begin
      if (adv) begin
        cx[l][0] <= GainQ;
        cy[l][0] <= '0;
        if (z0 > HalfPiQ) begin
          cz[l][0] <= z0 - PiQ; cn[l][0] <= 1'b1;
        end else if (z0 < -HalfPiQ) begin
          cz[l][0] <= z0 + PiQ; cn[l][0] <= 1'b1;
        end else begin
          cz[l][0] <= z0; cn[l][0] <= 1'b0;
        end
      end
    end
    for (genvar i = 0; i < CS; i++) begin : g_it
      always_ff @(posedge clk) begin
        if (adv) begin
          cn[l][i+1] <= cn[l][i];
          if (cz[l][i] >= 0) begin
            cx[l][i+1] <= cx[l][i] - (cy[l][i] >>> i);
            cy[l][i+1] <= cy[l][i] + (cx[l][i] >>> i);
            cz[l][i+1] <= cz[l][i] - atan_q(i);
          end else begin
            cx[l][i+1] <= cx[l][i] + (cy[l][i] >>> i);
            cy[l][i+1] <= cy[l][i] - (cx[l][i] >>> i);
            cz[l][i+1] <= cz[l][i] + atan_q(i);
          end
        end
      end
    end
  end

  logic signed [VW-1:0] sF, cF, sT, cT, sP, cP;
  assign cF = cn[0][CS] ? -cx[0][CS] : cx[0][CS];
  assign sF = cn[0][CS] ? -cy[0][CS] : cy[0][CS];
  assign cT = cn[1][CS] ? -cx[1][CS] : cx[1][CS];
  assign sT = cn[1][CS] ? -cy[1][CS] : cy[1][CS];
  assign cP = cn[2][CS] ? -cx[2][CS] : cx[2][CS];
  assign sP = cn[2][CS] ? -cy[2][CS] : cy[2][CS];

  // ---------------- DCM ----------------
  // stage A: first products
  logic signed [VW-1:0] a_c00, a_c01, a_c02, a_c12, a_c22, a_sfst, a_cfst;
  logic signed [VW-1:0] a_cfsp, a_cfcp, a_sfsp, a_sfcp, a_sp, a_cp;
  always_ff @(posedge clk) begin
    if (adv) begin
      a_c00 <= qmul(cT, cP);  a_c01 <= qmul(cT, sP);  a_c02 <= -sT;
      a_c12 <= qmul(sF, cT);  a_c22 <= qmul(cF, cT);
      a_sfst <= qmul(sF, sT); a_cfst <= qmul(cF, sT);
      a_cfsp <= qmul(cF, sP); a_cfcp <= qmul(cF, cP);
      a_sfsp <= qmul(sF, sP); a_sfcp <= qmul(sF, cP);
      a_sp <= sP; a_cp <= cP;
    end
  end
  // stage B: second products
  logic signed [VW-1:0] b_c00, b_c01, b_c02, b_c12, b_c22;
  logic signed [VW-1:0] b_p10, b_p11, b_p20, b_p21;
  logic signed [VW-1:0] b_cfsp, b_cfcp, b_sfsp, b_sfcp;
  always_ff @(posedge clk) begin
    if (adv) begin
      b_c00 <= a_c00; b_c01 <= a_c01; b_c02 <= a_c02; b_c12 <= a_c12; b_c22 <= a_c22;
      b_p10 <= qmul(a_sfst, a_cp); b_p11 <= qmul(a_sfst, a_sp);
      b_p20 <= qmul(a_cfst, a_cp); b_p21 <= qmul(a_cfst, a_sp);
      b_cfsp <= a_cfsp; b_cfcp <= a_cfcp; b_sfsp <= a_sfsp; b_sfcp <= a_sfcp;
    end
  end
  // stage C: matrix entries
  logic signed [VW-1:0] c00, c01, c02, c10, c11, c12, c20, c21, c22;
  always_ff @(posedge clk) begin
    if (adv) begin
      c00 <= b_c00; c01 <= b_c01; c02 <= b_c02; c12 <= b_c12; c22 <= b_c22;
      c10 <= b_p10 - b_cfsp;
      c11 <= b_cfcp + b_p11;
      c20 <= b_p20 + b_sfsp;
      c21 <= b_p21 - b_sfcp;
    end
  end

  // ---------------- candidates and numerators ----------------
  logic signed [VW-1:0] t [4];
  logic signed [NumW-1:0] n_a, n_b, n_c, n_d, n_e, n_f;
  always_ff @(posedge clk) begin
    if (adv) begin
      t[0] <= (OneQ + c00 + c11 + c22) >>> 2;
      t[1] <= (OneQ + c00 - c11 - c22) >>> 2;
      t[2] <= (OneQ - c00 + c11 - c22) >>> 2;
      t[3] <= (OneQ - c00 - c11 + c22) >>> 2;
      n_a <= NumW'(c12) - NumW'(c21);
      n_b <= NumW'(c20) - NumW'(c02);
      n_c <= NumW'(c01) - NumW'(c10);
      n_d <= NumW'(c01) + NumW'(c10);
      n_e <= NumW'(c20) + NumW'(c02);
      n_f <= NumW'(c12) + NumW'(c21);
    end
  end
  // absolute value and radicand
  logic [SqW-1:0] rad0 [4];
  logic signed [NumW-1:0] m_a, m_b, m_c, m_d, m_e, m_f;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++)
        rad0[k] <= SqW'(t[k][VW-1] ? -t[k] : t[k]) << Frac;
      m_a <= n_a; m_b <= n_b; m_c <= n_c; m_d <= n_d; m_e <= n_e; m_f <= n_f;
    end
  end

  // ---------------- square roots, one result bit per stage ----------------
  logic [SqW-1:0] sv [4][SQ+1];
  logic [RootW-1:0] sr [4][SQ+1];
  logic signed [NumW-1:0] sn [6][SQ+1];
  assign sn[0][0] = m_a; assign sn[1][0] = m_b; assign sn[2][0] = m_c;
  assign sn[3][0] = m_d; assign sn[4][0] = m_e; assign sn[5][0] = m_f;
  for (genvar k = 0; k < 4; k++) begin : g_sq
    assign sv[k][0] = rad0[k];
    assign sr[k][0] = '0;
    for (genvar j = 0; j < SQ; j++) begin : g_st
      localparam int B = SQ - 1 - j;
      logic [SqW:0] trial;
      logic [SqW:0] rem;
      assign trial = ((SqW+1)'(sr[k][j]) << (B + 1)) + ((SqW+1)'(1) << (2*B));
      assign rem = {1'b0, sv[k][j]};
      always_ff @(posedge clk) begin
        if (adv) begin
          if (rem >= trial) begin
            sv[k][j+1] <= SqW'(rem - trial);
            sr[k][j+1] <= sr[k][j] | (RootW'(1) << B);
          end else begin
            sv[k][j+1] <= sv[k][j];
            sr[k][j+1] <= sr[k][j];
          end
        end
      end
    end
  end
  for (genvar k = 0; k < 6; k++) begin : g_nd
    for (genvar j = 0; j < SQ; j++) begin : g_st
      always_ff @(posedge clk) if (adv) sn[k][j+1] <= sn[k][j];
    end
  end

  // ---------------- select largest ----------------
  sel_t sel, sel_c;
  logic [RootW-1:0] big, big_c;
  logic signed [NumW-1:0] p0, p1, p2, p0_c, p1_c, p2_c;
  always_comb begin
    sel_c = SEL_S; big_c = sr[0][SQ];
    for (int k = 1; k < 4; k++)
      if (sr[k][SQ] > big_c) begin
        big_c = sr[k][SQ]; sel_c = sel_t'(k);
      end
    case (sel_c)
      SEL_S: begin p0_c = sn[0][SQ]; p1_c = sn[1][SQ]; p2_c = sn[2][SQ]; end
      SEL_X: begin p0_c = sn[0][SQ]; p1_c = sn[3][SQ]; p2_c = sn[4][SQ]; end
      SEL_Y: begin p0_c = sn[1][SQ]; p1_c = sn[3][SQ]; p2_c = sn[5][SQ]; end
      default: begin p0_c = sn[2][SQ]; p1_c = sn[4][SQ]; p2_c = sn[5][SQ]; end
    endcase
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sel <= sel_c; big <= big_c; p0 <= p0_c; p1 <= p1_c; p2 <= p2_c;
    end
  end

  // ---------------- three restoring dividers, one quotient bit per stage ----------------
  logic [DivNW-1:0] dq [3][DV+1];
  logic [DivDW:0]   dr [3][DV+1];
  logic             dneg [3][DV+1];
  logic [DivDW-1:0] dden [DV+1];
  logic [RootW-1:0] dbig [DV+1];
  sel_t             dsel [DV+1];
  logic signed [NumW-1:0] pin [3];
  assign pin[0] = p0; assign pin[1] = p1; assign pin[2] = p2;
  assign dden[0] = {big, 2'b00};
  assign dbig[0] = big;
  assign dsel[0] = sel;
  for (genvar k = 0; k < 3; k++) begin : g_dv
    logic [NumW-1:0] mag;
    assign mag = pin[k][NumW-1] ? NumW'(-pin[k]) : NumW'(pin[k]);
    assign dq[k][0] = {mag, 14'b0};
    assign dr[k][0] = '0;
    assign dneg[k][0] = pin[k][NumW-1];
    for (genvar j = 0; j < DV; j++) begin : g_st
      logic [DivDW:0] sh;
      assign sh = {dr[k][j][DivDW-1:0], dq[k][j][DivNW-1]};
      always_ff @(posedge clk) begin
        if (adv) begin
          dneg[k][j+1] <= dneg[k][j];
          if (sh >= {1'b0, dden[j]}) begin
            dr[k][j+1] <= sh - {1'b0, dden[j]};
            dq[k][j+1] <= {dq[k][j][DivNW-2:0], 1'b1};
          end else begin
            dr[k][j+1] <= sh;
            dq[k][j+1] <= {dq[k][j][DivNW-2:0], 1'b0};
          end
        end
      end
    end
  end
  for (genvar j = 0; j < DV; j++) begin : g_dp
    always_ff @(posedge clk) begin
      if (adv) begin
        dden[j+1] <= dden[j]; dbig[j+1] <= dbig[j]; dsel[j+1] <= dsel[j];
      end
    end
  end

  // ---------------- output assembly ----------------
  logic signed [QW-1:0] r [3];
  logic signed [QW-1:0] lg;
  logic [RootW-1:0] bigr;
  logic signed [QW-1:0] qs, qx, qy, qz;
  for (genvar k = 0; k < 3; k++) begin : g_r
    logic signed [DivNW-1:0] sq;
    assign sq = dneg[k][DV] ? -$signed(dq[k][DV]) : $signed(dq[k][DV]);
    assign r[k] = (dden[DV] == '0) ? '0 : sat14(sq);
  end
  assign bigr = dbig[DV] + RootW'(8192);
  assign lg = sat14(DivNW'(bigr >> 14));
  always_comb begin
    case (dsel[DV])
      SEL_S: begin qs = lg;   qx = r[0]; qy = r[1]; qz = r[2]; end
      SEL_X: begin qs = r[0]; qx = lg;   qy = r[1]; qz = r[2]; end
      SEL_Y: begin qs = r[0]; qx = r[1]; qy = lg;   qz = r[2]; end
      default: begin qs = r[0]; qx = r[1]; qy = r[2]; qz = lg; end
    endcase
  end
  // load only a valid result so a waiting one is never overwritten
  always_ff @(posedge clk) if (adv && vld[LAT-1]) out_data <= {qz, qy, qx, qs};

  // output register with skid: hold a result while the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0; skid_full <= 1'b0;
    end else begin
      if (skid_full) begin
        if (m_tready) skid_full <= 1'b0;
      end else if (adv) begin
        if (out_full && !m_tready) begin
          skid_full <= vld[LAT-1];
        end
        out_full <= vld[LAT-1] || (out_full && !m_tready);
      end
    end
  end
  // skid holds the older result while a newer one fills out_data
  always_ff @(posedge clk) begin
    if (!skid_full && out_full && !m_tready) skid_data <= out_data;
  end
  assign m_tvalid = skid_full || out_full;
  assign m_tdata = skid_full ? skid_data : out_data;

endmodule

@@ hw/rtl/e2q_checker.sv @@
// Port-level checker for euler_to_quaternion_top, bound to the top level.
// Depends on e2q_pkg.
`timescale 1ns / 1ps
module e2q_checker
  import e2q_pkg::*;
(
  input logic clk, rst, s_tready, m_tvalid, m_tready,
  input logic [63:0] m_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output dropped");
  a_s_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(m_tdata[15:0]) <= Q14Max && $signed(m_tdata[15:0]) >= -Q14Max)
    else $error("scalar out of range");
  a_x_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(m_tdata[31:16]) <= Q14Max && $signed(m_tdata[31:16]) >= -Q14Max)
    else $error("x out of range");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid) else $error("input stalled with no result waiting");
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid) else $error("valid after reset");
endmodule

bind euler_to_quaternion_top e2q_checker u_chk (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

@@ bench/euler_to_quaternion_top_tb.sv @@
// Testbench for euler_to_quaternion_top: drives angle triples, predicts each
// quaternion with a bit-exact fixed-point model and checks results in order.
// Depends on e2q_pkg and the block under test.
`timescale 1ns / 1ps

class quat_scoreboard;
  logic [63:0] pending[$];
  int errors = 0;

  function automatic longint floor_shr(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint fmul(longint a, longint b);
    return floor_shr(a * b, 28);
  endfunction

  function automatic longint clamp14(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  function automatic void cordic(logic signed [14:0] ang, output longint s,
                                 output longint c);
    longint z, x, y, dx, dy;
    bit neg;
    longint atan_lut[16];
    atan_lut = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
                 4193963, 2097109, 1048571, 524287, 262144, 131072, 65536,
                 32768, 16384, 8192};
    z = longint'(ang) * 65536;
    x = 163008218;
    y = 0;
    neg = 0;
    if (z > 421657428) begin
      z -= 843314857;
      neg = 1;
    end else if (z < -421657428) begin
      z += 843314857;
      neg = 1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_lut[i];
      end else begin
        x += dx; y -= dy; z += atan_lut[i];
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic longint root_q28(longint t);
    logic [63:0] v, r, b;
    v = (t < 0 ? -t : t);
    v = v << 28;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint divide_q14(longint num, longint m);
    if (m == 0) return 0;
    return clamp14((num * 16384) / (4 * m));
  endfunction

  function automatic logic [63:0] quaternion_of(logic [44:0] angles);
    longint sf, cf, st, ct, sp, cp;
    longint c00, c01, c02, c10, c11, c12, c20, c21, c22, big;
    longint m[4], q[4];
    int sel;
    cordic(angles[14:0], sf, cf);
    cordic(angles[29:15], st, ct);
    cordic(angles[44:30], sp, cp);
    c00 = fmul(ct, cp);
    c01 = fmul(ct, sp);
    c02 = -st;
    c10 = fmul(fmul(sf, st), cp) - fmul(cf, sp);
    c11 = fmul(cf, cp) + fmul(fmul(sf, st), sp);
    c12 = fmul(sf, ct);
    c20 = fmul(fmul(cf, st), cp) + fmul(sf, sp);
    c21 = fmul(fmul(cf, st), sp) - fmul(sf, cp);
    c22 = fmul(cf, ct);
    m[0] = root_q28(floor_shr(268435456 + c00 + c11 + c22, 2));
    m[1] = root_q28(floor_shr(268435456 + c00 - c11 - c22, 2));
    m[2] = root_q28(floor_shr(268435456 - c00 + c11 - c22, 2));
    m[3] = root_q28(floor_shr(268435456 - c00 - c11 + c22, 2));
    sel = 0;
    for (int k = 1; k < 4; k++) if (m[k] > m[sel]) sel = k;
    big = m[sel];
    case (sel)
      e2q_pkg::SEL_S: begin
        q[1] = divide_q14(c12 - c21, big);
        q[2] = divide_q14(c20 - c02, big);
        q[3] = divide_q14(c01 - c10, big);
      end
      e2q_pkg::SEL_X: begin
        q[0] = divide_q14(c12 - c21, big);
        q[2] = divide_q14(c01 + c10, big);
        q[3] = divide_q14(c20 + c02, big);
      end
      e2q_pkg::SEL_Y: begin
        q[0] = divide_q14(c20 - c02, big);
        q[1] = divide_q14(c01 + c10, big);
        q[3] = divide_q14(c12 + c21, big);
      end
      default: begin
        q[0] = divide_q14(c01 - c10, big);
        q[1] = divide_q14(c20 + c02, big);
        q[2] = divide_q14(c12 + c21, big);
      end
    endcase
    q[sel] = clamp14((big + 8192) >>> 14);
    return {q[3][15:0], q[2][15:0], q[1][15:0], q[0][15:0]};
  endfunction

  function void note_angles(logic [47:0] tdata);
    pending.push_back(quaternion_of(tdata[44:0]));
  endfunction

  function void check_quat(logic [63:0] got);
    logic [63:0] want;
    string fname[4];
    fname = '{"quat_scalar", "quat_x", "quat_y", "quat_z"};
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    for (int k = 0; k < 4; k++)
      if (want[16*k +: 16] !== got[16*k +: 16]) begin
        $display("%0t: %s expected %0d actual %0d", $time, fname[k],
                 $signed(want[16*k +: 16]), $signed(got[16*k +: 16]));
        errors++;
      end
  endfunction
endclass

module euler_to_quaternion_top_tb;
  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [47:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [63:0] m_tdata;
  int send_idle = 0;
  int recv_idle = 0;
  longint cycles = 0;
  quat_scoreboard sb;

  euler_to_quaternion_top u_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_angles(s_tdata);
    if (!rst && m_tvalid && m_tready) sb.check_quat(m_tdata);
    m_tready <= !rst && ($urandom_range(99) >= recv_idle);
  end

  function automatic logic [14:0] pick_angle();
    case ($urandom_range(9))
      0: return 15'h3FFF;
      1: return 15'h4000;
      2: return 15'(-12868);
      3: return 15'd12868;
      4: return 15'($urandom_range(6434 + 40, 6434 - 40));
      5: return 15'(-$urandom_range(6434 + 40, 6434 - 40));
      6: return 15'($urandom_range(20) - 10);
      7: return 15'($urandom);
      default: return 15'($urandom_range(25736) - 12868);
    endcase
  endfunction

  task automatic send_angles(logic [14:0] r, logic [14:0] p, logic [14:0] y);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {3'b0, y, p, r};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  initial begin
    logic [14:0] edge_vals[8];
    sb = new();
    edge_vals = '{15'h0, 15'h3FFF, 15'h4000, 15'd12868, 15'(-12868), 15'd6434,
                  15'(-6434), 15'h7FFF};
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_idle = 26; recv_idle = 77;
    for (int i = 0; i < 8; i++) send_angles(edge_vals[i], '0, '0);
    for (int i = 0; i < 8; i++) send_angles('0, edge_vals[i], '0);
    for (int i = 0; i < 8; i++) send_angles(edge_vals[i], edge_vals[7 - i], edge_vals[i]);
    for (int i = 0; i < 450; i++) send_angles(pick_angle(), pick_angle(), pick_angle());
    drain();
    send_idle = 77; recv_idle = 26;
    for (int i = 0; i < 450; i++) send_angles(pick_angle(), pick_angle(), pick_angle());
    send_idle = 0; recv_idle = 0;
    for (int i = 0; i < 450; i++) send_angles(pick_angle(), pick_angle(), pick_angle());
    drain();
    repeat (150) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

@@ euler_to_quaternion_top.f @@
hw/rtl/e2q_pkg.sv
hw/rtl/euler_to_quaternion_top.sv
hw/rtl/e2q_checker.sv
bench/euler_to_quaternion_top_tb.sv
